/* hw/rtl/stcov_pkg.sv */
// Package for the segment tree interval cover block.
// Holds the sizing constants, status codes and shared structs.
// No dependencies; every other RTL file except stcov_ram imports it.
`default_nettype none

package stcov_pkg;

  // Tree span and count width
  localparam int RANGE_SPAN  = 1024;
  localparam int COVER_BITS  = 16;
  localparam int SPAN_LOG    = $clog2(RANGE_SPAN);
  localparam int POS_W       = SPAN_LOG + 1;
  localparam int IDX_W       = SPAN_LOG + 1;
  localparam int LVL_W       = $clog2(SPAN_LOG + 1);
  localparam int STORE_DEPTH = 2 * RANGE_SPAN;

  // Traversal stack
  localparam int PEND_DEPTH  = 20;
  localparam int PEND_AW     = $clog2(PEND_DEPTH);
  localparam int CNT_W       = $clog2(PEND_DEPTH + 1);

  // Fixed transaction field widths
  localparam int IN_W        = 11;
  localparam int NODE_OUT_W  = 11;
  localparam int COVER_OUT_W = 16;
  localparam int STATUS_W    = 2;

  localparam logic [COVER_BITS-1:0] COVER_MAX = '1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_UNDER = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

  // One tree node: heap index plus its depth below the root
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [LVL_W-1:0] lvl;
  } node_t;

  // Node classification against the current interval
  typedef struct packed {
    logic covered;
    logic push_r;
    logic push_l;
  } span_res_t;

  // Request to the cover store
  typedef struct packed {
    logic                   we;
    logic [IDX_W-1:0]       waddr;
    logic [COVER_BITS-1:0]  wdata;
    logic [IDX_W-1:0]       raddr;
  } mem_req_t;

  // Clamp an endpoint to the span
  function automatic logic [POS_W-1:0] sat_pos(input logic [IN_W-1:0] v);
    if (int'(v) > RANGE_SPAN) begin
      sat_pos = POS_W'(RANGE_SPAN);
    end else begin
      sat_pos = POS_W'(v);
    end
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/stcov_if.sv */
// Valid/ready channel interfaces for request and result transactions.
// Depends on stcov_pkg for the field widths.
`default_nettype none

interface stcov_in_if import stcov_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [IN_W-1:0]  interval_start;
  logic [IN_W-1:0]  interval_end;

  modport source(output valid, req_type, interval_start, interval_end, input ready);
  modport sink(input valid, req_type, interval_start, interval_end, output ready);
endinterface

interface stcov_out_if import stcov_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [NODE_OUT_W-1:0]   node_index;
  logic [COVER_OUT_W-1:0]  new_cover;
  logic [STATUS_W-1:0]     status;
  logic                    last;

  modport source(output valid, node_index, new_cover, status, last, input ready);
  modport sink(input valid, node_index, new_cover, status, last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/stcov_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
`default_nettype none

module stcov_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/stcov_span.sv */
// Shared node unit: derives a node's span from its index and depth,
// compares it with the interval and forms both children. Uses stcov_pkg.
`default_nettype none

module stcov_span import stcov_pkg::*; (
  input  wire node_t            node,
  input  wire logic [POS_W-1:0] s,
  input  wire logic [POS_W-1:0] e,
  output node_t                 left_child,
  output node_t                 right_child,
  output span_res_t             res
);

  logic [IDX_W-1:0] offset;
  logic [LVL_W-1:0] sh;
  logic [POS_W-1:0] lo;
  logic [POS_W-1:0] size;
  logic [POS_W-1:0] hi;
  logic [POS_W-1:0] mid;
  logic             leaf;

  // Span [lo, hi) of the node, split point mid
  always_comb begin
    offset = node.idx & ~(IDX_W'(1) << node.lvl);
    sh     = LVL_W'(SPAN_LOG) - node.lvl;
    lo     = POS_W'(offset) << sh;
    size   = POS_W'(RANGE_SPAN) >> node.lvl;
    hi     = lo + size;
    mid    = lo + (size >> 1);
    leaf   = (node.lvl == LVL_W'(SPAN_LOG));
  end

  // Classify and pick the children that still meet the interval
  always_comb begin
    res.covered = (s <= lo) && (hi <= e);
    res.push_r  = !res.covered && !leaf && (e > mid);
    res.push_l  = !res.covered && !leaf && (s < mid);
  end

  always_comb begin
    left_child.idx  = node.idx << 1;
    left_child.lvl  = node.lvl + LVL_W'(1);
    right_child.idx = {node.idx[IDX_W-2:0], 1'b1};
    right_child.lvl = node.lvl + LVL_W'(1);
  end

endmodule

`default_nettype wire

/* hw/rtl/stcov_ctrl.sv */
// Sequencer: clearing pass, preorder walk over a node stack, cover count
// read-modify-write and the result register. Uses stcov_pkg, stcov_if, stcov_span.
`default_nettype none

module stcov_ctrl import stcov_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  stcov_in_if.sink                    in_ch,
  stcov_out_if.source                 out_ch,
  output mem_req_t                    mem_req,
  input  wire logic [COVER_BITS-1:0]  mem_rdata
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_POP   = 4'b0100,
    S_UPD   = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [IDX_W-1:0]     clr_r, clr_nxt;
  logic                 out_valid_r, out_valid_nxt;

  node_t                stack_r [PEND_DEPTH];
  logic [POS_W-1:0]     s_r, e_r;
  logic                 del_r;
  logic [IDX_W-1:0]     cur_idx_r;
  logic [NODE_OUT_W-1:0]  out_node_r;
  logic [COVER_OUT_W-1:0] out_cover_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic                 out_last_r;

  logic [PEND_AW-1:0]   pop_ptr;
  node_t                top_node;
  node_t                left_child, right_child;
  span_res_t            span_res;

  logic                 in_fire;
  logic                 out_free;
  logic                 upd_go;
  logic [POS_W-1:0]     s_in, e_in;
  logic [CNT_W-1:0]     c1, c2;
  logic                 wa_en, wb_en;
  logic [PEND_AW-1:0]   wa_ptr, wb_ptr;
  node_t                wa_node, wb_node;
  logic [COVER_BITS-1:0] new_c;
  status_t              new_st;

  // Top of the node stack and its classification
  assign pop_ptr  = PEND_AW'(cnt_r - CNT_W'(1));
  assign top_node = stack_r[pop_ptr];

  stcov_span u_span (
    .node        (top_node),
    .s           (s_r),
    .e           (e_r),
    .left_child  (left_child),
    .right_child (right_child),
    .res         (span_res)
  );

  // Handshakes
  assign in_ch.ready = (state_r == S_IDLE) && !out_valid_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign upd_go      = (state_r == S_UPD) && out_free;
  assign s_in        = sat_pos(in_ch.interval_start);
  assign e_in        = sat_pos(in_ch.interval_end);

  // Saturating count update
  always_comb begin
    new_c  = mem_rdata;
    new_st = ST_OK;
    if (del_r) begin
      if (mem_rdata == '0) begin
        new_st = ST_UNDER;
      end else begin
        new_c = mem_rdata - COVER_BITS'(1);
      end
    end else begin
      if (mem_rdata == COVER_MAX) begin
        new_st = ST_SAT;
      end else begin
        new_c = mem_rdata + COVER_BITS'(1);
      end
    end
  end

  // Stack pushes: the root on an accepted request; after a pop, right child first, so left is popped first
  always_comb begin
    c1      = cnt_r - CNT_W'(1);
    c2      = c1;
    wa_en   = 1'b0;
    wb_en   = 1'b0;
    wa_ptr  = PEND_AW'(c1);
    wa_node = right_child;
    wb_ptr  = PEND_AW'(c1);
    wb_node = left_child;
    if (state_r == S_POP && !span_res.covered) begin
      if (span_res.push_r && c1 < CNT_W'(PEND_DEPTH)) begin
        wa_en = 1'b1;
        c2    = c1 + CNT_W'(1);
      end
      wb_ptr = PEND_AW'(c2);
      if (span_res.push_l && c2 < CNT_W'(PEND_DEPTH)) begin
        wb_en = 1'b1;
        c2    = c2 + CNT_W'(1);
      end
    end else if (in_fire) begin
      wa_en        = 1'b1;
      wa_ptr       = '0;
      wa_node.idx  = IDX_W'(1);
      wa_node.lvl  = '0;
    end
  end

  // Next state
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + IDX_W'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          if (s_in >= e_in) begin
            out_valid_nxt = 1'b1;
          end else begin
            cnt_nxt   = CNT_W'(1);
            state_nxt = S_POP;
          end
        end
      end
      S_POP: begin
        if (span_res.covered) begin
          cnt_nxt   = c1;
          state_nxt = S_UPD;
        end else begin
          cnt_nxt = c2;
          if (c2 == '0) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_UPD: begin
        if (upd_go) begin
          out_valid_nxt = 1'b1;
          state_nxt     = (cnt_r == '0) ? S_IDLE : S_POP;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        clr_nxt   = '0;
      end
    endcase
  end

  // Cover store access
  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.waddr = cur_idx_r;
    mem_req.wdata = new_c;
    mem_req.raddr = (state_r == S_POP) ? top_node.idx : cur_idx_r;
    if (state_r == S_CLEAR) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = clr_r;
      mem_req.wdata = '0;
    end else if (upd_go) begin
      mem_req.we = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: request, stack, current node, result
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_r   <= s_in;
      e_r   <= e_in;
      del_r <= in_ch.req_type;
    end
    if (wa_en) begin
      stack_r[wa_ptr] <= wa_node;
    end
    if (wb_en) begin
      stack_r[wb_ptr] <= wb_node;
    end
    if (state_r == S_POP) begin
      cur_idx_r <= top_node.idx;
    end
    if (in_fire && s_in >= e_in) begin
      out_node_r   <= '0;
      out_cover_r  <= '0;
      out_status_r <= ST_EMPTY;
      out_last_r   <= 1'b1;
    end else if (upd_go) begin
      out_node_r   <= NODE_OUT_W'(cur_idx_r);
      out_cover_r  <= COVER_OUT_W'(new_c);
      out_status_r <= new_st;
      out_last_r   <= (cnt_r == '0);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.node_index = out_node_r;
  assign out_ch.new_cover  = out_cover_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.last       = out_last_r;

endmodule

`default_nettype wire

/* hw/rtl/segment_tree_interval_cover.sv */
// Segment tree interval cover counter, top level. After reset a clearing pass
// zeroes all 2048 cover counts; no request is taken meanwhile. Empty interval:
// one result, registered in the cycle after the request. Otherwise the walk
// pops each split node, and reads then updates each covered node, the update
// waiting while a result is unsent; one request at a time, bounded by the cover
// store port. Uses stcov_pkg, stcov_if, stcov_ram, stcov_ctrl.
`default_nettype none

module segment_tree_interval_cover import stcov_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  stcov_in_if.sink     in_ch,
  stcov_out_if.source  out_ch
);

  mem_req_t              mem_req;
  logic [COVER_BITS-1:0] mem_rdata;

  stcov_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  stcov_ram #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (COVER_BITS)
  ) u_store (
    .clk     (clk),
    .we      (mem_req.we),
    .waddr   (mem_req.waddr),
    .wdata   (mem_req.wdata),
    .raddr   (mem_req.raddr),
    .rdata_r (mem_rdata)
  );

  // A new request never lands on an unsent result
  a_in_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |-> !out_ch.valid)
    else $error("request accepted while a result is pending");

  // Empty interval answers with a single status transaction
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready &&
    (sat_pos(in_ch.interval_start) >= sat_pos(in_ch.interval_end))
    |=> out_ch.valid && out_ch.last && out_ch.node_index == '0 &&
        out_ch.status == ST_EMPTY)
    else $error("empty interval not answered by a status result");

  // Underflow holds the count at zero
  a_under_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == ST_UNDER |-> out_ch.new_cover == '0)
    else $error("underflow result with nonzero count");

  // Saturation holds the count at its maximum, and touched nodes are real
  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == ST_SAT |->
      out_ch.new_cover == COVER_OUT_W'(COVER_MAX) && out_ch.node_index != '0)
    else $error("saturated result with wrong count or node");

endmodule

`default_nettype wire

/* tb/segment_tree_interval_cover_tb.sv */
`timescale 1ns / 1ps
// Testbench for segment_tree_interval_cover: directed and random interval requests,
// checked node by node against a cover-count scoreboard. Depends on stcov_pkg and stcov_if.

module segment_tree_interval_cover_tb import stcov_pkg::*; ();

  localparam int RANDOM_ITEMS        = 300;
  localparam int BACKPRESSURE_CYCLES = 400;
  localparam int WATCHDOG_LIMIT      = 10000;
  localparam int DRAIN_CYCLES        = 80;
  localparam int MISMATCH_PRINT_MAX  = 200;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  // Tracks the cover count of every node and the node updates still due
  class cover_scoreboard;
    typedef struct packed {
      logic [NODE_OUT_W-1:0]  node;
      logic [COVER_OUT_W-1:0] count;
      status_t                status;
      logic                   last;
    } node_update_t;

    logic [COVER_BITS-1:0] node_count [STORE_DEPTH];
    node_update_t          due_updates [$];
    int errors;
    int requests;
    int updates;
    int n_empty;
    int n_sat;
    int n_under;

    function new();
      foreach (node_count[i]) node_count[i] = '0;
      errors   = 0;
      requests = 0;
      updates  = 0;
      n_empty  = 0;
      n_sat    = 0;
      n_under  = 0;
    endfunction

    // Span [lo,hi) of the node at heap index idx
    function void node_bounds(input int unsigned idx, output int unsigned lo,
                              output int unsigned hi);
      int unsigned first;
      int unsigned size;
      first = 1;
      size  = RANGE_SPAN;
      while (first <= (idx >> 1) && size > 1) begin
        first <<= 1;
        size  >>= 1;
      end
      lo = (idx - first) * size;
      hi = lo + size;
    endfunction

    // Walk the canonical decomposition in preorder and queue one update per covered node
    function void apply_request(input logic del, input logic [IN_W-1:0] s_in,
                                input logic [IN_W-1:0] e_in);
      int unsigned s;
      int unsigned e;
      int unsigned idx;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      int unsigned depth;
      int unsigned walk [PEND_DEPTH];
      logic [COVER_BITS-1:0] c;
      status_t st;
      node_update_t upd;

      requests++;
      s = (s_in > RANGE_SPAN) ? RANGE_SPAN : s_in;
      e = (e_in > RANGE_SPAN) ? RANGE_SPAN : e_in;

      // Empty interval: one status transaction, no change
      if (s >= e) begin
        upd.node   = '0;
        upd.count  = '0;
        upd.status = ST_EMPTY;
        upd.last   = 1'b1;
        due_updates.push_back(upd);
        n_empty++;
        return;
      end

      walk[0] = 1;
      depth   = 1;
      while (depth > 0) begin
        depth--;
        idx = walk[depth];
        if (idx == 0 || idx >= STORE_DEPTH) continue;
        node_bounds(idx, lo, hi);
        if (s <= lo && hi <= e) begin
          c  = node_count[idx];
          st = ST_OK;
          if (del) begin
            if (c == '0) st = ST_UNDER;
            else c = c - 1'b1;
          end else begin
            if (c == COVER_MAX) st = ST_SAT;
            else c = c + 1'b1;
          end
          node_count[idx] = c;
          upd.node   = NODE_OUT_W'(idx);
          upd.count  = COVER_OUT_W'(c);
          upd.status = st;
          upd.last   = (depth == 0);
          due_updates.push_back(upd);
          if (st == ST_SAT) n_sat++;
          if (st == ST_UNDER) n_under++;
        end else if (hi - lo >= 2) begin
          // Push right before left so the left child comes out first
          mid = lo + (hi - lo) / 2;
          if (e > mid && depth < PEND_DEPTH) begin
            walk[depth] = 2 * idx + 1;
            depth++;
          end
          if (s < mid && depth < PEND_DEPTH) begin
            walk[depth] = 2 * idx;
            depth++;
          end
        end
      end
    endfunction

    function void report(input string field, input longint exp_v, input longint act_v);
      errors++;
      if (errors <= MISMATCH_PRINT_MAX)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, exp_v, act_v);
    endfunction

    // Compare one result transaction with the oldest update due
    function void match_update(input logic [NODE_OUT_W-1:0] node,
                               input logic [COVER_OUT_W-1:0] count,
                               input logic [STATUS_W-1:0] status, input logic last);
      node_update_t exp_u;
      updates++;
      if (due_updates.size() == 0) begin
        errors++;
        if (errors <= MISMATCH_PRINT_MAX)
          $display("%0t: unexpected result: expected none, actual node %0d count %0d",
                   $time, node, count);
        return;
      end
      exp_u = due_updates.pop_front();
      if (node !== exp_u.node) report("node_index", exp_u.node, node);
      if (count !== exp_u.count) report("new_cover", exp_u.count, count);
      if (status !== exp_u.status) report("status", exp_u.status, status);
      if (last !== exp_u.last) report("last", exp_u.last, last);
    endfunction

    function int outstanding();
      return due_updates.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   idle_on;
  bit   backpressure_arm;
  bit   backpressure_done = 1'b0;
  int   quiet_cycles = 0;

  cover_scoreboard sb = new();

  stcov_in_if  in_ch ();
  stcov_out_if out_ch ();

  segment_tree_interval_cover dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offer one request and hold it until the block takes it
  task automatic send_request(input logic rt, input int s, input int e);
    if (idle_on && $urandom_range(99) < 18) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.req_type       <= rt;
    in_ch.interval_start <= IN_W'(s);
    in_ch.interval_end   <= IN_W'(e);
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Result side: random stalls, plus one long hold-off to back the block up
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (backpressure_arm && !backpressure_done) begin
        backpressure_done = 1'b1;
        hold_left = BACKPRESSURE_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(idle_on && $urandom_range(99) < 18);
      end
    end
  end

  // Sample both channels and watch for a hung block
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        sb.match_update(out_ch.node_index, out_ch.new_cover, out_ch.status, out_ch.last);
      if (in_ch.valid && in_ch.ready)
        sb.apply_request(in_ch.req_type, in_ch.interval_start, in_ch.interval_end);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results still due",
                 $time, WATCHDOG_LIMIT, sb.outstanding());
        $display("segment_tree_interval_cover_tb: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    int i;
    int pick;
    int s;
    int e;
    logic rt;

    idle_on           = 1'b1;
    backpressure_arm  = 1'b0;
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.req_type       <= REQ_INSERT;
    in_ch.interval_start <= '0;
    in_ch.interval_end   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: whole span, underflow, single leaves, widest split, empty and clamped ranges
    send_request(REQ_INSERT, 0, RANGE_SPAN);
    send_request(REQ_DELETE, 0, RANGE_SPAN);
    send_request(REQ_DELETE, 0, RANGE_SPAN);
    send_request(REQ_INSERT, 0, 1);
    send_request(REQ_INSERT, RANGE_SPAN - 1, RANGE_SPAN);
    send_request(REQ_INSERT, 1, RANGE_SPAN - 1);
    send_request(REQ_DELETE, 1, RANGE_SPAN - 1);
    send_request(REQ_INSERT, 5, 5);
    send_request(REQ_INSERT, 700, 300);
    send_request(REQ_DELETE, 2047, 2047);
    send_request(REQ_INSERT, RANGE_SPAN, 2047);
    send_request(REQ_INSERT, 2047, 0);
    send_request(REQ_DELETE, 0, 0);
    send_request(REQ_INSERT, 0, 2047);
    send_request(REQ_DELETE, 512, 2047);
    send_request(REQ_INSERT, 0, 512);
    send_request(REQ_INSERT, 512, RANGE_SPAN);
    send_request(REQ_DELETE, 511, 513);
    send_request(REQ_INSERT, 3, RANGE_SPAN - 3);
    send_request(REQ_DELETE, 1, RANGE_SPAN - 1);
    send_request(REQ_DELETE, 1023, 1024);
    send_request(REQ_INSERT, 1365, 682);
    send_request(REQ_DELETE, 682, 1365);

    // Random: mostly well-formed intervals, some short, plus noise and empty ranges
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      idle_on = !(i >= 200 && i < 260);
      if (i == 120) backpressure_arm = 1'b1;
      rt   = ($urandom_range(99) < 45) ? REQ_DELETE : REQ_INSERT;
      pick = $urandom_range(99);
      if (pick < 50) begin
        s = $urandom_range(RANGE_SPAN - 1, 0);
        e = $urandom_range(RANGE_SPAN, s + 1);
      end else if (pick < 80) begin
        s = $urandom_range(RANGE_SPAN - 1, 0);
        e = s + $urandom_range(16, 1);
        if (e > RANGE_SPAN) e = RANGE_SPAN;
      end else if (pick < 92) begin
        s = $urandom_range(2047, 0);
        e = $urandom_range(2047, 0);
      end else begin
        e = $urandom_range(2047, 0);
        s = $urandom_range(2047, e);
      end
      send_request(rt, s, e);
    end
    in_ch.valid <= 1'b0;

    // Drain, then give the block time to show any stray result
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests (%0d empty) and %0d node results.",
             sb.requests, sb.n_empty, sb.updates);
    $display("Saw %0d saturated inserts, %0d underflowing deletes, %0d mismatches.",
             sb.n_sat, sb.n_under, sb.errors);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("segment_tree_interval_cover_tb: PASS");
    end else begin
      $display("segment_tree_interval_cover_tb: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/stcov_pkg.sv
hw/rtl/stcov_if.sv
hw/rtl/stcov_ram.sv
hw/rtl/stcov_span.sv
hw/rtl/stcov_ctrl.sv
hw/rtl/segment_tree_interval_cover.sv
tb/segment_tree_interval_cover_tb.sv
